### design/cssq_pkg.sv
// ----------------------------------------------------------------------------
// cssq_pkg
// Shared widths, constants and types for the consecutive square sum test.
// ----------------------------------------------------------------------------
package cssq_pkg;

	localparam int FIELD_W   = 20;
	localparam int SUM_OUT_W = 63;

	localparam logic [FIELD_W-1:0] RUN_LENGTH_RST = FIELD_W'(1);

	localparam logic [3:0] NIB_MASK = 4'hF;
	localparam logic [3:0] NIB_SQ_0 = 4'h0;
	localparam logic [3:0] NIB_SQ_1 = 4'h1;
	localparam logic [3:0] NIB_SQ_4 = 4'h4;
	localparam logic [3:0] NIB_SQ_9 = 4'h9;

	typedef struct packed {
		logic adv;
		logic vld;
	} stage_ctl_t;

	function automatic logic nib_can_be_square(input logic [3:0] low);
		logic [3:0] nib;
		nib = low & NIB_MASK;
		return (nib == NIB_SQ_0) || (nib == NIB_SQ_1) || (nib == NIB_SQ_4) ||
			(nib == NIB_SQ_9);
	endfunction

endpackage

### design/cssq_prefix.sv
// ----------------------------------------------------------------------------
// cssq_prefix
// Six-stage pipeline for S(m) = m(m+1)(2m+1)/6, exact, forced to zero on demand.
// ----------------------------------------------------------------------------
module cssq_prefix
	import cssq_pkg::*;
#(
	parameter int INDEX_BITS = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stage_ctl_t              ctl,
	input  logic [INDEX_BITS:0]     m,
	input  logic                    zero,
	output logic                    vld,
	output logic [3*INDEX_BITS+1:0] sum
);

	localparam int M_W   = INDEX_BITS + 1;
	localparam int F_W   = INDEX_BITS + 2;
	localparam int T_W   = 2 * INDEX_BITS + 1;
	localparam int SUM_W = 3 * INDEX_BITS + 2;
	localparam int D_N   = (M_W + 1) / 2;
	localparam logic [63:0] INV3_FULL = ((F_W % 2) == 0) ?
		(((64'd1 << (F_W + 1)) + 64'd1) / 64'd3) : (((64'd1 << F_W) + 64'd1) / 64'd3);
	localparam logic [F_W-1:0] INV3 = INV3_FULL[F_W-1:0];

	typedef enum logic [1:0] {
		SEL_F0,
		SEL_F1,
		SEL_F2
	} div_sel_t;

	function automatic logic [1:0] mod3(input logic [M_W-1:0] v);
		logic [2*D_N-1:0] pv;
		logic [7:0]       acc;
		logic [3:0]       r2;
		logic [2:0]       r3;
		pv  = (2*D_N)'(v);
		acc = '0;
		for (int d = 0; d < D_N; d++) begin
			acc = acc + 8'(pv[2*d +: 2]);
		end
		r2 = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]) + 4'(acc[7:6]);
		r3 = 3'(r2[1:0]) + 3'(r2[3:2]);
		if (r3 >= 3'd3) begin
			r3 = r3 - 3'd3;
		end
		return r3[1:0];
	endfunction

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                 zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic [M_W-1:0]       m_s1;
	logic [F_W-1:0]       f0_s2, f1_s2, f2_s2;
	div_sel_t             sel_s2;
	logic [F_W-1:0]       g0_s3, g1_s3, g2_s3;
	logic [T_W-1:0]       t_s4;
	logic [F_W-1:0]       g2_s4;
	logic [2*INDEX_BITS+2:0] pl_s5;
	logic [2*INDEX_BITS+1:0] ph_s5;
	logic [SUM_W-1:0]     sum_s6;

	logic [F_W-1:0]   fa, fb, fc;
	logic [1:0]       r;
	logic [F_W-1:0]   f0_d, f1_d;
	div_sel_t         sel_d;
	logic [F_W-1:0]   dsel;
	logic [2*F_W-1:0] dprod;
	logic [F_W-1:0]   q;
	logic [2*F_W-1:0] tprod;
	logic [SUM_W-1:0] sum_d;

	always_comb begin
		fa = F_W'(m_s1);
		fb = fa + F_W'(1);
		fc = {m_s1, 1'b1};
		r  = mod3(m_s1);
		if (!m_s1[0]) begin
			f0_d = fa >> 1;
			f1_d = fb;
		end else begin
			f0_d = fb >> 1;
			f1_d = fa;
		end
		case (r)
			2'd0:    sel_d = m_s1[0] ? SEL_F1 : SEL_F0;
			2'd1:    sel_d = SEL_F2;
			default: sel_d = m_s1[0] ? SEL_F0 : SEL_F1;
		endcase
	end

	always_comb begin
		unique case (sel_s2)
			SEL_F0:  dsel = f0_s2;
			SEL_F1:  dsel = f1_s2;
			SEL_F2:  dsel = f2_s2;
			default: dsel = f2_s2;
		endcase
		dprod = dsel * INV3;
		q     = dprod[F_W-1:0];
		tprod = g0_s3 * g1_s3;
		sum_d = SUM_W'(pl_s5) + SUM_W'({ph_s5, {(INDEX_BITS+1){1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			m_s1    <= m;
			zero_s1 <= zero;
			f0_s2   <= f0_d;
			f1_s2   <= f1_d;
			f2_s2   <= fc;
			sel_s2  <= sel_d;
			zero_s2 <= zero_s1;
			g0_s3   <= (sel_s2 == SEL_F0) ? q : f0_s2;
			g1_s3   <= (sel_s2 == SEL_F1) ? q : f1_s2;
			g2_s3   <= (sel_s2 == SEL_F2) ? q : f2_s2;
			zero_s3 <= zero_s2;
			t_s4    <= tprod[T_W-1:0];
			g2_s4   <= g2_s3;
			zero_s4 <= zero_s3;
			pl_s5   <= t_s4[INDEX_BITS:0] * g2_s4;
			ph_s5   <= t_s4[T_W-1:INDEX_BITS+1] * g2_s4;
			zero_s5 <= zero_s4;
			sum_s6  <= zero_s5 ? '0 : sum_d;
		end
	end

	assign vld = vld_s6;
	assign sum = sum_s6;

endmodule

### design/cssq_isqrt.sv
// ----------------------------------------------------------------------------
// cssq_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cssq_isqrt
	import cssq_pkg::*;
#(
	parameter int SUM_W = 62
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stage_ctl_t       ctl,
	input  logic [SUM_W-1:0] x,
	output logic             vld,
	output logic [SUM_W-1:0] sum,
	output logic             is_sq
);

	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int XP_W   = 2 * ROOT_W;
	localparam int RW     = ROOT_W + 2;

	logic              vld_s  [ROOT_W];
	logic [XP_W-1:0]   x_s    [ROOT_W];
	logic [RW-1:0]     rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W-1];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam int J = ROOT_W - 1 - i;

		logic              vld_in;
		logic [XP_W-1:0]   x_in;
		logic [RW-3:0]     rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RW-1:0]     rem_sh;
		logic [RW-1:0]     trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign vld_in  = ctl.vld;
			assign x_in    = XP_W'(x);
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign x_in    = x_s[i-1];
			assign rem_in  = rem_s[i-1][RW-3:0];
			assign root_in = root_s[i-1];
		end

		assign rem_sh = {rem_in, x_in[2*J +: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				x_s[i]   <= x_in;
				rem_s[i] <= ge ? rem_sh - trial : rem_sh;
			end
		end

		if (i < ROOT_W - 1) begin : g_root
			always_ff @(posedge clk) begin
				if (ctl.adv) begin
					root_s[i] <= {root_in[ROOT_W-2:0], ge};
				end
			end
		end
	end

	assign vld   = vld_s[ROOT_W-1];
	assign sum   = x_s[ROOT_W-1][SUM_W-1:0];
	assign is_sq = (rem_s[ROOT_W-1] == '0) && nib_can_be_square(x_s[ROOT_W-1][3:0]);

endmodule

### design/consecutive_square_sum_square_test_top.sv
// ----------------------------------------------------------------------------
// consecutive_square_sum_square_test_top
// Sum of run_length consecutive squares from start_index, with perfect-square flag.
// ----------------------------------------------------------------------------
//  channel    | handshake                   | payload
//  item       | item_valid / item_ready     | start_index
//  result     | result_valid / result_ready | square_sum, is_square
//  config     | cfg_wen                     | cfg_wdata (run_length)
//
//  One transaction enters per cycle while item_ready is high; results pass
//  the input, prefix, difference, square root and output buffer stages.
//  ROOT_W = (3*INDEX_BITS + 3) / 2 (31 at INDEX_BITS = 20) is the root width, one bit per root stage.
//  Reset clears all valid bits; run_length returns to 1.
//  A two-entry output buffer holds results; the pipeline freezes only while
//  its second entry is full.
// ----------------------------------------------------------------------------
module consecutive_square_sum_square_test_top
	import cssq_pkg::*;
#(
	parameter int INDEX_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [FIELD_W-1:0]   cfg_wdata,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [FIELD_W-1:0]   start_index,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [SUM_OUT_W-1:0] square_sum,
	output logic                 is_square
);

	localparam int M_W   = INDEX_BITS + 1;
	localparam int SUM_W = 3 * INDEX_BITS + 2;

	logic [FIELD_W-1:0]    run_length_q;
	logic                  en;
	logic                  vld_s1;
	logic [INDEX_BITS-1:0] s_s1, k_s1;
	logic [M_W-1:0]        m_hi, m_lo;
	logic                  zero_hi, zero_lo;
	logic                  hi_vld, lo_vld;
	logic [SUM_W-1:0]      hi_sum, lo_sum;
	logic                  vld_s2;
	logic [SUM_W-1:0]      sum_s2;
	logic                  sq_vld, sq_flag;
	logic [SUM_W-1:0]      sq_sum;
	logic                  push, take;
	logic                  out_vld_q, out_sq_q;
	logic [SUM_W-1:0]      out_sum_q;
	logic                  skid_vld_q, skid_sq_q;
	logic [SUM_W-1:0]      skid_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= RUN_LENGTH_RST;
		end else if (cfg_wen) begin
			run_length_q <= cfg_wdata;
		end
	end

	assign en         = !skid_vld_q;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= hi_vld & lo_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= start_index[INDEX_BITS-1:0];
			k_s1   <= run_length_q[INDEX_BITS-1:0];
			sum_s2 <= hi_sum - lo_sum;
		end
	end

	assign m_hi    = {1'b0, s_s1} + {1'b0, k_s1} - M_W'(1);
	assign m_lo    = {1'b0, s_s1} - M_W'(1);
	assign zero_hi = (k_s1 == '0);
	assign zero_lo = (k_s1 == '0) || (s_s1 == '0);

	cssq_prefix #(
		.INDEX_BITS(INDEX_BITS)
	) u_prefix_hi (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   ('{adv: en, vld: vld_s1}),
		.m     (m_hi),
		.zero  (zero_hi),
		.vld   (hi_vld),
		.sum   (hi_sum)
	);

	cssq_prefix #(
		.INDEX_BITS(INDEX_BITS)
	) u_prefix_lo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   ('{adv: en, vld: vld_s1}),
		.m     (m_lo),
		.zero  (zero_lo),
		.vld   (lo_vld),
		.sum   (lo_sum)
	);

	cssq_isqrt #(
		.SUM_W(SUM_W)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   ('{adv: en, vld: vld_s2}),
		.x     (sum_s2),
		.vld   (sq_vld),
		.sum   (sq_sum),
		.is_sq (sq_flag)
	);

	assign push = en && sq_vld;
	assign take = out_vld_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_vld_q) begin
			if (skid_vld_q) begin
				out_sum_q <= skid_sum_q;
				out_sq_q  <= skid_sq_q;
			end else begin
				out_sum_q <= sq_sum;
				out_sq_q  <= sq_flag;
			end
		end else if (push) begin
			skid_sum_q <= sq_sum;
			skid_sq_q  <= sq_flag;
		end
	end

	assign result_valid = out_vld_q;
	assign square_sum   = SUM_OUT_W'(out_sum_q);
	assign is_square    = out_sq_q;

endmodule

### design/cssq_checker.sv
// ----------------------------------------------------------------------------
// cssq_checker
// Port-level checks for the consecutive square sum test, bound to the top level.
// ----------------------------------------------------------------------------
module cssq_checker
	import cssq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input logic [SUM_OUT_W-1:0] square_sum,
	input logic                 is_square
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(square_sum) && $stable(is_square))
		else $error("result transaction changed while stalled");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("item channel stalled with no result pending");

	a_square_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_square |->
			(square_sum[3:0] == NIB_SQ_0) || (square_sum[3:0] == NIB_SQ_1) ||
			(square_sum[3:0] == NIB_SQ_4) || (square_sum[3:0] == NIB_SQ_9))
		else $error("square flag on a sum whose low nibble is no square");

	a_zero_is_square: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (square_sum == '0) |-> is_square)
		else $error("zero sum not flagged as square");

endmodule

bind consecutive_square_sum_square_test_top cssq_checker u_cssq_checker (.*);
